>>> src/tpbf_pkg.sv
// Package with the types and constants of the tile parameter block framer.
package tpbf_pkg;

   typedef struct packed {
      logic        kind;
      logic [63:0] word0;
      logic [63:0] word1;
      logic [63:0] word2;
      logic [63:0] word3;
   } req_type;

   typedef struct packed {
      logic [63:0] out_word0;
      logic [63:0] out_word1;
      logic [63:0] out_word2;
      logic [63:0] out_word3;
      logic [2:0]  handler;
      logic        is_long;
      logic        half_index;
      logic        last;
      logic [4:0]  vertex_format;
   } rsp_type;

   // Request kinds.
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // Parameter types from control word bits 31:29.
   localparam logic [2:0] PTYPE_POLY   = 3'd4;
   localparam logic [2:0] PTYPE_SPRITE = 3'd5;
   localparam logic [2:0] PTYPE_VERTEX = 3'd7;

   // Handler codes.
   localparam logic [2:0] HND_NONE     = 3'd0;
   localparam logic [2:0] HND_LIST_END = 3'd1;
   localparam logic [2:0] HND_USER_CLIP = 3'd2;
   localparam logic [2:0] HND_OBJ_LIST = 3'd3;
   localparam logic [2:0] HND_POLY     = 3'd4;
   localparam logic [2:0] HND_SPRITE   = 3'd5;
   localparam logic [2:0] HND_VERTEX   = 3'd6;

   // Handler code for each parameter type, indexed by type.
   localparam logic [2:0] HANDLER_TABLE [8] = '{
      HND_LIST_END, HND_USER_CLIP, HND_OBJ_LIST, HND_NONE,
      HND_POLY, HND_SPRITE, HND_NONE, HND_VERTEX
   };

   // Vertex formats beyond the polygon table.
   localparam logic [4:0] FMT_SPRITE0 = 5'd15;
   localparam logic [4:0] FMT_SPRITE1 = 5'd16;
   localparam logic [4:0] FMT_VOLUME  = 5'd17;
   localparam logic [4:0] FMT_NONE    = 5'd18;

endpackage

>>> src/tile_param_block_framer.sv
// Top level of the tile parameter block framer: classification, half holding, output queue.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_data  (tpbf_pkg::req_type)
//   rsp      out        rsp_valid/rsp_ready   rsp_data  (tpbf_pkg::rsp_type)
//
// A request is registered when it is accepted, and its results enter the output register
// from that input register as soon as the output register can take them. One request is
// taken per cycle while req_ready is high. A request that completes a long parameter makes
// two results; no result-making request behind it advances until the queued second drains.
// Reset (synchronous, active high) drops any held half and sets the kept format to none.
// With the result side stalled, the output and input registers fill before req_ready drops.
module tile_param_block_framer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tpbf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tpbf_pkg::rsp_type rsp_data
);

   // Input register.
   logic              in_valid_ff, in_valid_in;
   tpbf_pkg::req_type in_ff;

   // Framer state.
   logic        pending_ff, pending_in;
   logic [4:0]  fmt_ff, fmt_in;
   logic [63:0] held_ff [4];

   // Output register: the visible result and one queued second result.
   logic              out_valid_ff, out_valid_in;
   logic              sec_valid_ff, sec_valid_in;
   tpbf_pkg::rsp_type out_ff, out_in;
   tpbf_pkg::rsp_type sec_ff;

   // Decode of the registered request.
   logic [31:0] pcw;
   logic [2:0]  ptype;
   logic [2:0]  list_type;
   logic        tex, vol, uv16;
   logic [1:0]  col;
   logic [4:0]  hdr_fmt;
   logic        hdr_long;
   logic        vtx_long;
   logic        is_long;
   logic        completing;
   logic        holding;
   logic        emit;
   logic        out_can_take;
   logic        advance;
   logic [2:0]  held_handler;
   tpbf_pkg::rsp_type first_rsp, second_rsp;

   assign pcw       = in_ff.word0[31:0];
   assign ptype     = pcw[31:29];
   assign list_type = pcw[26:24];
   assign tex       = pcw[3];
   assign col       = pcw[5:4];
   assign vol       = pcw[6];
   assign uv16      = pcw[0];

   // Header classification into a vertex format and a header size.
   always_comb begin
      hdr_fmt  = 5'd0;
      hdr_long = 1'b0;
      if (ptype == tpbf_pkg::PTYPE_SPRITE) begin
         hdr_fmt = tex ? tpbf_pkg::FMT_SPRITE1 : tpbf_pkg::FMT_SPRITE0;
      end else if (list_type == 3'd1 || list_type == 3'd3) begin
         // Modifier volume lists.
         hdr_fmt = tpbf_pkg::FMT_VOLUME;
      end else if (!tex && !vol) begin
         case (col)
            2'd0: hdr_fmt = 5'd0;
            2'd1: hdr_fmt = 5'd1;
            2'd2: begin
               hdr_fmt  = 5'd2;
               hdr_long = 1'b1;
            end
            default: hdr_fmt = 5'd2;
         endcase
      end else if (!tex && vol) begin
         case (col)
            2'd0: hdr_fmt = 5'd9;
            2'd1: hdr_fmt = 5'd0;
            2'd2: begin
               hdr_fmt  = 5'd10;
               hdr_long = 1'b1;
            end
            default: hdr_fmt = 5'd10;
         endcase
      end else if (!vol) begin
         case (col)
            2'd0: hdr_fmt = uv16 ? 5'd4 : 5'd3;
            2'd1: hdr_fmt = uv16 ? 5'd6 : 5'd5;
            2'd2: begin
               hdr_fmt  = uv16 ? 5'd8 : 5'd7;
               hdr_long = 1'b1;
            end
            default: hdr_fmt = uv16 ? 5'd8 : 5'd7;
         endcase
      end else begin
         case (col)
            2'd0: hdr_fmt = uv16 ? 5'd12 : 5'd11;
            2'd1: hdr_fmt = 5'd0;
            2'd2: begin
               hdr_fmt  = uv16 ? 5'd14 : 5'd13;
               hdr_long = 1'b1;
            end
            default: hdr_fmt = uv16 ? 5'd14 : 5'd13;
         endcase
      end
   end

   // Vertex size from the kept format; "none" counts as 32 bytes.
   always_comb begin
      case (fmt_ff)
         5'd5, 5'd6, 5'd11, 5'd12, 5'd13, 5'd14,
         tpbf_pkg::FMT_SPRITE0, tpbf_pkg::FMT_SPRITE1, tpbf_pkg::FMT_VOLUME:
            vtx_long = 1'b1;
         default:
            vtx_long = 1'b0;
      endcase
   end

   // Data block sizing, the new kept format, and what the block produces.
   always_comb begin
      fmt_in  = fmt_ff;
      is_long = 1'b0;
      if (ptype == tpbf_pkg::PTYPE_VERTEX) begin
         is_long = vtx_long;
      end else if (ptype == tpbf_pkg::PTYPE_POLY || ptype == tpbf_pkg::PTYPE_SPRITE) begin
         is_long = hdr_long;
         fmt_in  = hdr_fmt;
      end
      // A restart or a completing block leaves the kept format alone.
      if (in_ff.kind == tpbf_pkg::KIND_RESTART || pending_ff) begin
         fmt_in = fmt_ff;
      end
   end

   assign completing = (in_ff.kind == tpbf_pkg::KIND_DATA) && pending_ff;
   assign holding    = (in_ff.kind == tpbf_pkg::KIND_DATA) && !pending_ff && is_long;
   assign emit       = (in_ff.kind == tpbf_pkg::KIND_DATA) && !holding;

   assign held_handler = tpbf_pkg::HANDLER_TABLE[held_ff[0][31:29]];

   // Result fields for the current request.
   always_comb begin
      first_rsp.out_word0     = completing ? held_ff[0] : in_ff.word0;
      first_rsp.out_word1     = completing ? held_ff[1] : in_ff.word1;
      first_rsp.out_word2     = completing ? held_ff[2] : in_ff.word2;
      first_rsp.out_word3     = completing ? held_ff[3] : in_ff.word3;
      first_rsp.handler       = completing ? held_handler : tpbf_pkg::HANDLER_TABLE[ptype];
      first_rsp.is_long       = completing;
      first_rsp.half_index    = 1'b0;
      first_rsp.last          = !completing;
      first_rsp.vertex_format = fmt_in;

      second_rsp.out_word0     = in_ff.word0;
      second_rsp.out_word1     = in_ff.word1;
      second_rsp.out_word2     = in_ff.word2;
      second_rsp.out_word3     = in_ff.word3;
      second_rsp.handler       = held_handler;
      second_rsp.is_long       = 1'b1;
      second_rsp.half_index    = 1'b1;
      second_rsp.last          = 1'b1;
      second_rsp.vertex_format = fmt_in;
   end

   // The output register takes new results when it is empty or drains its
   // only result this cycle.
   assign out_can_take = !sec_valid_ff && (!out_valid_ff || rsp_ready);
   assign advance      = in_valid_ff && (!emit || out_can_take);
   assign req_ready    = !in_valid_ff || advance;

   assign in_valid_in = req_valid || (in_valid_ff && !advance);

   always_comb begin
      pending_in = pending_ff;
      if (advance) begin
         pending_in = holding;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      sec_valid_in = sec_valid_ff;
      out_in       = out_ff;
      if (advance && emit) begin
         out_valid_in = 1'b1;
         sec_valid_in = completing;
         out_in       = first_rsp;
      end else if (out_valid_ff && rsp_ready) begin
         out_valid_in = sec_valid_ff;
         sec_valid_in = 1'b0;
         out_in       = sec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pending_ff   <= 1'b0;
         fmt_ff       <= tpbf_pkg::FMT_NONE;
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pending_ff   <= pending_in;
         fmt_ff       <= advance ? fmt_in : fmt_ff;
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_ff <= req_data;
      end
      out_ff <= out_in;
      if (advance && completing) begin
         sec_ff <= second_rsp;
      end
      if (advance && holding) begin
         held_ff[0] <= in_ff.word0;
         held_ff[1] <= in_ff.word1;
         held_ff[2] <= in_ff.word2;
         held_ff[3] <= in_ff.word3;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // A queued second result always sits behind a visible first result.
   a_sec_behind_out: assert property (@(posedge clock) disable iff (reset)
      sec_valid_ff |-> out_valid_ff)
      else $error("queued second half without a visible first half");

   // The first half of a long parameter is always followed by its second half.
   a_first_half_pairs: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.is_long && !out_ff.half_index) |-> sec_valid_ff)
      else $error("long first half without a queued second half");

   // The queued result is always the closing half of a long parameter.
   a_sec_is_last: assert property (@(posedge clock) disable iff (reset)
      sec_valid_ff |-> (sec_ff.half_index && sec_ff.last && sec_ff.is_long))
      else $error("queued result is not a closing second half");

   // No result-making request advances while a second half waits to be shown.
   a_no_accept_with_sec: assert property (@(posedge clock) disable iff (reset)
      (sec_valid_ff && in_valid_ff && emit) |-> !advance)
      else $error("result overwrote a queued second half");

endmodule
